@@ hdl/dmac_pkg.sv @@
package dmac_pkg;

   localparam int NUM_CHANNELS = 4;
   localparam int CH_W = 2;
   localparam int UNITS_W = 17;

   // request function codes
   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_TICK  = 2'd2;

   // register selects
   localparam logic [1:0] REG_SRC   = 2'd0;
   localparam logic [1:0] REG_DST   = 2'd1;
   localparam logic [1:0] REG_COUNT = 2'd2;
   localparam logic [1:0] REG_CTL   = 2'd3;

   // address step modes
   localparam logic [1:0] ADDR_INC   = 2'd0;
   localparam logic [1:0] ADDR_DEC   = 2'd1;
   localparam logic [1:0] ADDR_FIXED = 2'd2;
   localparam logic [1:0] ADDR_BAD   = 2'd3;

   // start modes
   localparam logic [1:0] START_IMM    = 2'd0;
   localparam logic [1:0] START_VBLANK = 2'd1;
   localparam logic [1:0] START_HBLANK = 2'd2;

   // control bit positions
   localparam int CTL_DMODE_LO = 5;
   localparam int CTL_SMODE_LO = 7;
   localparam int CTL_REPEAT   = 9;
   localparam int CTL_WORD     = 10;
   localparam int CTL_START_LO = 12;
   localparam int CTL_IRQ      = 14;
   localparam int CTL_ENABLE   = 15;

   localparam logic [UNITS_W-1:0] UNITS_LAST_CH = 17'h10000;
   localparam logic [UNITS_W-1:0] UNITS_OTHER   = 17'h04000;
   localparam logic [CH_W-1:0]    LAST_CH       = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [1:0]  chan_sel;
      logic [1:0]  reg_sel;
      logic [31:0] write_data;
      logic        in_vblank;
      logic        in_hblank;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        xfer_valid;
      logic [31:0] xfer_src;
      logic [31:0] xfer_dst;
      logic        xfer_is_word;
      logic [1:0]  xfer_channel;
      logic        xfer_last;
      logic [3:0]  irq_mask;
      logic        bad_source_mode;
   } rsp_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   function automatic logic [31:0] step_addr(input logic [31:0] a, input logic [1:0] mode,
                                             input logic [31:0] size);
      logic [31:0] r;
      case (mode)
         ADDR_DEC:   r = a - size;
         ADDR_FIXED: r = a;
         default:    r = a + size;
      endcase
      return r;
   endfunction

endpackage

@@ hdl/dmac_ctrl.sv @@
module dmac_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dmac_pkg::status_type status,
   output dmac_pkg::cmd_type    cmd
);

   dmac_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dmac_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.exec    = 1'b0;
      case (state_ff)
         dmac_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = dmac_pkg::ST_EXEC;
            end
         end
         dmac_pkg::ST_EXEC: begin
            // wait for the output slot before touching state
            if (status.out_free) begin
               cmd.exec = 1'b1;
               state_in = dmac_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dmac_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ hdl/dmac_dp.sv @@
module dmac_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  dmac_pkg::req_type    req_data,
   input  dmac_pkg::cmd_type    cmd,
   output dmac_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dmac_pkg::rsp_type    rsp_data
);

   localparam int N  = dmac_pkg::NUM_CHANNELS;
   localparam int CW = dmac_pkg::CH_W;
   localparam int UW = dmac_pkg::UNITS_W;

   logic [31:0] source_ff [N];
   logic [31:0] source_in [N];
   logic [31:0] dest_ff   [N];
   logic [31:0] dest_in   [N];
   logic [15:0] count_ff  [N];
   logic [15:0] count_in  [N];
   logic [15:0] control_ff[N];
   logic [15:0] control_in[N];

   logic          busy_ff, busy_in;
   logic [CW-1:0] busy_ch_ff, busy_ch_in;
   logic [31:0]   cur_src_ff, cur_src_in;
   logic [31:0]   cur_dst_ff, cur_dst_in;
   logic [UW-1:0] units_ff, units_in;

   dmac_pkg::req_type req_ff, req_in;
   dmac_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [N-1:0]  start_ok;
   logic          pick_found;
   logic [CW-1:0] pick_ch;
   logic [CW-1:0] idx;
   logic          ch_ok;

   // per-channel start condition
   always_comb begin
      for (int c = 0; c < N; c++) begin
         case (control_ff[c][dmac_pkg::CTL_START_LO +: 2])
            dmac_pkg::START_IMM:    start_ok[c] = control_ff[c][dmac_pkg::CTL_ENABLE];
            dmac_pkg::START_VBLANK: start_ok[c] = control_ff[c][dmac_pkg::CTL_ENABLE]
                                                  & req_ff.in_vblank;
            dmac_pkg::START_HBLANK: start_ok[c] = control_ff[c][dmac_pkg::CTL_ENABLE]
                                                  & req_ff.in_hblank;
            default:                start_ok[c] = 1'b0;
         endcase
      end
   end

   // lowest channel wins
   always_comb begin
      pick_found = 1'b0;
      pick_ch    = '0;
      for (int c = 0; c < N; c++) begin
         if (start_ok[c] && !pick_found) begin
            pick_found = 1'b1;
            pick_ch    = CW'(c);
         end
      end
   end

   // one shared register-file index per item
   always_comb begin
      if (req_ff.func == dmac_pkg::FUNC_TICK) begin
         idx = busy_ff ? busy_ch_ff : pick_ch;
      end else begin
         idx = req_ff.chan_sel[CW-1:0];
      end
   end

   assign ch_ok = ({1'b0, req_ff.chan_sel} < 3'(N));

   always_comb begin
      logic          eff_busy;
      logic [31:0]   eff_src;
      logic [31:0]   eff_dst;
      logic [UW-1:0] eff_units;
      logic [UW-1:0] units_dec;
      logic [15:0]   ctl;
      logic [31:0]   size;

      source_in  = source_ff;
      dest_in    = dest_ff;
      count_in   = count_ff;
      control_in = control_ff;
      busy_in    = busy_ff;
      busy_ch_in = busy_ch_ff;
      cur_src_in = cur_src_ff;
      cur_dst_in = cur_dst_ff;
      units_in   = units_ff;
      req_in     = cmd.capture ? req_data : req_ff;
      rsp_in     = rsp_ff;

      eff_busy  = busy_ff;
      eff_src   = cur_src_ff;
      eff_dst   = cur_dst_ff;
      eff_units = units_ff;
      ctl       = control_ff[idx];
      size      = ctl[dmac_pkg::CTL_WORD] ? 32'd4 : 32'd2;
      units_dec = '0;

      if (cmd.exec) begin
         rsp_in = '0;
         case (req_ff.func)
            dmac_pkg::FUNC_WRITE: begin
               if (ch_ok) begin
                  case (req_ff.reg_sel)
                     dmac_pkg::REG_SRC:   source_in[idx]  = req_ff.write_data;
                     dmac_pkg::REG_DST:   dest_in[idx]    = req_ff.write_data;
                     dmac_pkg::REG_COUNT: count_in[idx]   = req_ff.write_data[15:0];
                     default:             control_in[idx] = req_ff.write_data[15:0];
                  endcase
               end
            end
            dmac_pkg::FUNC_READ: begin
               if (ch_ok) begin
                  case (req_ff.reg_sel)
                     dmac_pkg::REG_SRC: rsp_in.read_data = source_ff[idx];
                     dmac_pkg::REG_DST: rsp_in.read_data = dest_ff[idx];
                     dmac_pkg::REG_COUNT: begin
                        if (busy_ff && busy_ch_ff == idx) begin
                           rsp_in.read_data = {16'd0, units_ff[15:0]};
                        end else begin
                           rsp_in.read_data = {16'd0, count_ff[idx]};
                        end
                     end
                     default: rsp_in.read_data = {16'd0, control_ff[idx]};
                  endcase
               end
            end
            dmac_pkg::FUNC_TICK: begin
               if (!busy_ff && pick_found) begin
                  eff_busy = 1'b1;
                  eff_src  = source_ff[idx];
                  eff_dst  = dest_ff[idx];
                  if (count_ff[idx] == 16'd0) begin
                     eff_units = (idx == dmac_pkg::LAST_CH) ? dmac_pkg::UNITS_LAST_CH
                                                            : dmac_pkg::UNITS_OTHER;
                  end else begin
                     eff_units = {1'b0, count_ff[idx]};
                  end
                  busy_in    = 1'b1;
                  busy_ch_in = idx;
                  cur_src_in = eff_src;
                  cur_dst_in = eff_dst;
                  units_in   = eff_units;
               end
               if (eff_busy) begin
                  rsp_in.xfer_valid   = 1'b1;
                  rsp_in.xfer_src     = eff_src;
                  rsp_in.xfer_dst     = eff_dst;
                  rsp_in.xfer_is_word = ctl[dmac_pkg::CTL_WORD];
                  rsp_in.xfer_channel = idx;
                  if (ctl[dmac_pkg::CTL_SMODE_LO +: 2] == dmac_pkg::ADDR_BAD) begin
                     // abort: enable drops, count register kept, no irq
                     rsp_in.xfer_last       = 1'b1;
                     rsp_in.bad_source_mode = 1'b1;
                     control_in[idx][dmac_pkg::CTL_ENABLE] = 1'b0;
                     busy_in  = 1'b0;
                     units_in = '0;
                  end else begin
                     units_dec  = eff_units - UW'(1);
                     cur_dst_in = dmac_pkg::step_addr(eff_dst,
                                     ctl[dmac_pkg::CTL_DMODE_LO +: 2], size);
                     cur_src_in = dmac_pkg::step_addr(eff_src,
                                     ctl[dmac_pkg::CTL_SMODE_LO +: 2], size);
                     units_in   = units_dec;
                     if (units_dec == '0) begin
                        rsp_in.xfer_last = 1'b1;
                        if (!ctl[dmac_pkg::CTL_REPEAT]) begin
                           control_in[idx][dmac_pkg::CTL_ENABLE] = 1'b0;
                           count_in[idx] = 16'd0;
                        end
                        if (ctl[dmac_pkg::CTL_IRQ]) begin
                           rsp_in.irq_mask[idx] = 1'b1;
                        end
                        busy_in = 1'b0;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid_in    = cmd.exec | (rsp_valid_ff & ~rsp_ready);
   assign status.out_free = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < N; c++) begin
            source_ff[c]  <= '0;
            dest_ff[c]    <= '0;
            count_ff[c]   <= '0;
            control_ff[c] <= '0;
         end
         busy_ff      <= 1'b0;
         busy_ch_ff   <= '0;
         cur_src_ff   <= '0;
         cur_dst_ff   <= '0;
         units_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         source_ff    <= source_in;
         dest_ff      <= dest_in;
         count_ff     <= count_in;
         control_ff   <= control_in;
         busy_ff      <= busy_in;
         busy_ch_ff   <= busy_ch_in;
         cur_src_ff   <= cur_src_in;
         cur_dst_ff   <= cur_dst_in;
         units_ff     <= units_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

endmodule

@@ hdl/four_channel_dma_controller.sv @@
// a request is captured into the request register in idle; its response is registered in execute
// a new request is taken only once execute for the previous one is done; execute waits for a free
// output slot, but a new request is taken while the previous response still waits in the output register
// reset (synchronous, active high) clears all channel registers, the running block and
// the output valid; every channel comes up disabled
module four_channel_dma_controller (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  dmac_pkg::req_type req_data,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dmac_pkg::rsp_type rsp_data
);

   // command and status between the sequencer and the datapath
   dmac_pkg::cmd_type    cmd;
   dmac_pkg::status_type status;

   // sequencer: idle takes a request, execute waits for a free output slot
   dmac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: channel registers, priority pick, address steppers,
   // unit counter and the response register
   dmac_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
